// ===== design/nps_pkg.sv =====
// Shared types and constants of the NMEA position sentence parser.
package nps_pkg;

   localparam int FRAC_DIGITS_DEF = 5;
   localparam int QUEUE_DEPTH     = 4;
   localparam int MIN_W           = 40;
   localparam int DEG_W           = 10;

   // One coordinate as the front leaves it at the end of a sentence
   typedef struct packed {
      logic             ok;
      logic             neg;
      logic [DEG_W-1:0] whole;
      logic [MIN_W-1:0] minutes;
      logic [2:0]       fcnt;
   } crec_type;

   // One finished sentence, handed from front to back
   typedef struct packed {
      logic [2:0]       status;
      logic             kind;
      crec_type         lat;
      crec_type         lon;
      logic             alt_ok;
      logic             alt_neg;
      logic [MIN_W-1:0] alt_val;
      logic [1:0]       alt_fcnt;
   } rec_type;

endpackage

// ===== design/nmea_position_sentence_parser_core.sv =====
// Top level of the NMEA GGA/RMC position sentence parser.
// Throughput: one byte per cycle unless the queue is full; one result per cycle can
// leave back to back while rsp_tready is high. A finished sentence passes the queue,
// the fraction padding stages and the four converter stages before it leaves.
// Reset: synchronous, clears scanner state, queue pointers and pipeline valid bits;
// the block takes a request in the first cycle after reset.
module nmea_position_sentence_parser_core
   import nps_pkg::*;
#(
   parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] byte_in
   input  logic         req_tlast,   // last byte of the sentence
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [2:0] status, [34:3] latitude, [66:35] longitude,
                                     // [98:67] altitude, [103:99] zero
   output logic [0:0]   rsp_tuser    // [0] kind (0 RMC, 1 GGA)
);

   logic        queue_full;
   logic        push;
   rec_type     push_rec;
   logic        pop;
   logic        head_valid;
   rec_type     head_rec;
   logic [2:0]  status;
   logic        kind;
   logic [31:0] lat, lon, alt;

   // Front: scan each request byte; a last byte pushes one finished sentence
   nps_front #(.FRAC_DIGITS(FRAC_DIGITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_rec   (push_rec)
   );

   // Queue: hold sentences while the converter is stalled by the consumer
   nps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   // Back: pad fractions, convert minutes, saturate and register the result
   nps_back #(.FRAC_DIGITS(FRAC_DIGITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (status),
      .rsp_kind   (kind),
      .rsp_lat    (lat),
      .rsp_lon    (lon),
      .rsp_alt    (alt)
   );

   assign rsp_tdata = {5'd0, alt, lon, lat, status};
   assign rsp_tuser = kind;

endmodule

// ===== design/nps_front.sv =====
// Byte scanner: checksum, sentence type, field split and digit accumulation.
module nps_front
   import nps_pkg::*;
#(
   parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       queue_full,
   output logic       push,
   output rec_type    push_rec
);

   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_BODY  = 2'd1;
   localparam logic [1:0] PH_HEX   = 2'd2;
   localparam logic [1:0] PH_BAD   = 2'd3;

   localparam logic [1:0] TY_NONE = 2'd0;
   localparam logic [1:0] TY_RMC  = 2'd1;
   localparam logic [1:0] TY_GGA  = 2'd2;
   localparam logic [1:0] TY_BAD  = 2'd3;

   localparam logic [1:0] NUM_INT  = 2'd0;
   localparam logic [1:0] NUM_FRAC = 2'd1;
   localparam logic [1:0] NUM_DONE = 2'd2;

   localparam logic [1:0] DIR_OTHER = 2'd0;
   localparam logic [1:0] DIR_N     = 2'd1;
   localparam logic [1:0] DIR_S     = 2'd2;
   localparam logic [1:0] DIR_W     = 2'd3;

   localparam int FL_NONEMPTY = 0;
   localparam int FL_POINT    = 1;
   localparam int FL_POINTBAD = 2;
   localparam int FL_DEGOK    = 3;
   localparam int FL_RUN      = 4;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_BADSUM = 3'd1;
   localparam logic [2:0] ST_UNSUP  = 3'd2;
   localparam logic [2:0] ST_FEW    = 3'd3;
   localparam logic [2:0] ST_NOFIX  = 3'd4;
   localparam logic [2:0] ST_EMPTY  = 3'd5;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   localparam logic [2:0] FMAX     = 3'(FRAC_DIGITS);
   localparam logic [2:0] ALT_FMAX = 3'd3;

   typedef struct packed {
      logic [MIN_W-1:0] acc;
      logic [1:0]       stage;
      logic [2:0]       fcnt;
      logic             got;
      logic             neg;
   } num_type;

   typedef struct packed {
      logic [6:0]       deg_short;
      logic [DEG_W-1:0] deg_long;
      num_type          min_short;
      num_type          min_long;
      logic [1:0]       dir;
      logic [4:0]       flags;
   } coord_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic num_type num_feed(num_type p, logic [7:0] c, logic [2:0] fmax,
                                        logic signok, logic idx0);
      num_type     r;
      logic [43:0] prod;
      r    = p;
      prod = ({4'd0, p.acc} << 3) + ({4'd0, p.acc} << 1) + {40'd0, c[3:0]};
      if (p.stage != NUM_DONE) begin
         if (is_digit(c)) begin
            if (p.stage == NUM_INT || p.fcnt < fmax) begin
               r.acc = (|prod[43:40]) ? {MIN_W{1'b1}} : prod[39:0];
               if (p.stage == NUM_FRAC) r.fcnt = p.fcnt + 3'd1;
            end
            r.got = 1'b1;
         end else if (c == CH_POINT && p.stage == NUM_INT) begin
            r.stage = NUM_FRAC;
         end else if (signok && idx0 && (c == CH_PLUS || c == CH_MINUS)) begin
            r.neg = (c == CH_MINUS);
         end else begin
            r.stage = NUM_DONE;
         end
      end
      return r;
   endfunction

   function automatic logic [1:0] dir_code(logic [7:0] c);
      case (c)
         8'h4E:   return DIR_N;
         8'h53:   return DIR_S;
         8'h57:   return DIR_W;
         default: return DIR_OTHER;
      endcase
   endfunction

   function automatic coord_type coord_feed(coord_type s, logic [7:0] c, logic [2:0] i);
      coord_type  r;
      logic       isd;
      logic [3:0] d;
      r   = s;
      isd = is_digit(c);
      d   = isd ? c[3:0] : 4'd0;
      r.flags[FL_NONEMPTY] = 1'b1;
      if (c == CH_POINT && !s.flags[FL_POINT]) begin
         r.flags[FL_POINT] = 1'b1;
         if (i < 3'd2) r.flags[FL_POINTBAD] = 1'b1;
      end
      if (i == 3'd0) begin
         if (isd) begin
            r.flags[FL_DEGOK] = 1'b1;
            r.flags[FL_RUN]   = 1'b1;
            r.deg_short       = {3'd0, d};
            r.deg_long        = {6'd0, d};
         end
      end else if (i < 3'd3 && s.flags[FL_RUN]) begin
         if (isd) begin
            if (i < 3'd2) r.deg_short = 7'(s.deg_short * 7'd10 + {3'd0, d});
            r.deg_long = 10'(s.deg_long * 10'd10 + {6'd0, d});
         end else begin
            r.flags[FL_RUN] = 1'b0;
         end
      end
      if (i >= 3'd2) r.min_short = num_feed(s.min_short, c, FMAX, 1'b0, 1'b0);
      if (i >= 3'd3) r.min_long  = num_feed(s.min_long, c, FMAX, 1'b0, 1'b0);
      return r;
   endfunction

   function automatic crec_type coord_rec(coord_type s, logic st_ok);
      crec_type r;
      logic     narrow;
      num_type  mp;
      narrow    = (s.dir == DIR_N) || (s.dir == DIR_S);
      mp        = narrow ? s.min_short : s.min_long;
      r.neg     = (s.dir == DIR_S) || (s.dir == DIR_W);
      r.whole   = narrow ? {3'd0, s.deg_short} : s.deg_long;
      r.minutes = mp.acc;
      r.fcnt    = mp.fcnt;
      r.ok      = st_ok && s.flags[FL_POINT] && !s.flags[FL_POINTBAD]
                  && s.flags[FL_DEGOK] && mp.got;
      return r;
   endfunction

   logic [1:0] phase_ff, phase_in;
   logic [7:0] csum_ff, csum_in;
   logic [7:0] rsum_ff, rsum_in;
   logic [1:0] hexcnt_ff, hexcnt_in;
   logic [2:0] tpos_ff, tpos_in;
   logic [1:0] stype_ff, stype_in;
   logic [3:0] fnum_ff, fnum_in;
   logic [2:0] fpos_ff, fpos_in;
   logic       valid_ff, valid_in;
   coord_type  crd_ff [2];
   coord_type  crd_in [2];
   num_type    alt_ff, alt_in;

   logic       accept;
   logic [7:0] c;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign push       = accept && req_tlast;

   always_comb begin
      logic       hv_ok;
      logic [3:0] hv;
      logic [2:0] p;
      hv_ok     = 1'b0;
      hv        = 4'd0;
      p         = 3'd0;
      phase_in  = phase_ff;
      csum_in   = csum_ff;
      rsum_in   = rsum_ff;
      hexcnt_in = hexcnt_ff;
      tpos_in   = tpos_ff;
      stype_in  = stype_ff;
      fnum_in   = fnum_ff;
      fpos_in   = fpos_ff;
      valid_in  = valid_ff;
      crd_in[0] = crd_ff[0];
      crd_in[1] = crd_ff[1];
      alt_in    = alt_ff;
      if (phase_ff == PH_START) begin
         phase_in = (c == CH_DOLLAR) ? PH_BODY : PH_BAD;
      end else if (phase_ff != PH_BAD) begin
         if (phase_ff == PH_BODY) begin
            if (c == CH_STAR) phase_in = PH_HEX;
            else csum_in = csum_ff ^ c;
         end else if (hexcnt_ff < 2'd2) begin
            if (is_digit(c)) begin
               hv_ok = 1'b1;
               hv    = c[3:0];
            end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
               hv_ok = 1'b1;
               hv    = c[3:0] + 4'd9;
            end
            if (hv_ok) begin
               rsum_in   = {rsum_ff[3:0], hv};
               hexcnt_in = hexcnt_ff + 2'd1;
            end else begin
               hexcnt_in = 2'd3;
            end
         end
         if (tpos_ff < 3'd5) begin
            p       = tpos_ff + 3'd1;
            tpos_in = p;
            if (stype_ff != TY_BAD) begin
               case (p)
                  3'd1: if (c != 8'h47) stype_in = TY_BAD;
                  3'd2: if (c != 8'h50 && c != 8'h4E) stype_in = TY_BAD;
                  3'd3: stype_in = (c == 8'h52) ? TY_RMC : (c == 8'h47) ? TY_GGA : TY_BAD;
                  3'd4: if (c != ((stype_ff == TY_RMC) ? 8'h4D : 8'h47)) stype_in = TY_BAD;
                  3'd5: if (c != ((stype_ff == TY_RMC) ? 8'h43 : 8'h41)) stype_in = TY_BAD;
                  default: stype_in = stype_ff;
               endcase
            end
         end
         if (c == CH_COMMA) begin
            if (fnum_ff != 4'd15) fnum_in = fnum_ff + 4'd1;
            fpos_in = 3'd0;
         end else begin
            if (stype_in == TY_RMC) begin
               case (fnum_ff)
                  4'd2: valid_in = (fpos_ff == 3'd0) && (c == 8'h41);
                  4'd3: crd_in[0] = coord_feed(crd_ff[0], c, fpos_ff);
                  4'd4: crd_in[0].dir = (fpos_ff == 3'd0) ? dir_code(c) : DIR_OTHER;
                  4'd5: crd_in[1] = coord_feed(crd_ff[1], c, fpos_ff);
                  4'd6: crd_in[1].dir = (fpos_ff == 3'd0) ? dir_code(c) : DIR_OTHER;
                  default: valid_in = valid_ff;
               endcase
            end else if (stype_in == TY_GGA) begin
               case (fnum_ff)
                  4'd2: crd_in[0] = coord_feed(crd_ff[0], c, fpos_ff);
                  4'd3: crd_in[0].dir = (fpos_ff == 3'd0) ? dir_code(c) : DIR_OTHER;
                  4'd4: crd_in[1] = coord_feed(crd_ff[1], c, fpos_ff);
                  4'd5: crd_in[1].dir = (fpos_ff == 3'd0) ? dir_code(c) : DIR_OTHER;
                  4'd6: valid_in = (fpos_ff == 3'd0) && (c == CH_ZERO);
                  4'd9: alt_in = num_feed(alt_ff, c, ALT_FMAX, 1'b1, fpos_ff == 3'd0);
                  default: valid_in = valid_ff;
               endcase
            end
            if (fpos_ff != 3'd7) fpos_in = fpos_ff + 3'd1;
         end
      end
   end

   // Status of the sentence as it stands after this byte
   always_comb begin
      logic [4:0] count;
      logic       kind;
      logic       st_ok;
      logic [2:0] st;
      count = {1'b0, fnum_in} + ((c != CH_COMMA) ? 5'd1 : 5'd0);
      kind  = 1'b0;
      st    = ST_OK;
      if (!(phase_in == PH_HEX && hexcnt_in == 2'd2 && rsum_in == csum_in)) begin
         st = ST_BADSUM;
      end else if (tpos_in != 3'd5 || (stype_in != TY_RMC && stype_in != TY_GGA)) begin
         st = ST_UNSUP;
      end else begin
         kind = (stype_in == TY_GGA);
         if (count < (kind ? 5'd10 : 5'd7)) st = ST_FEW;
         else if (kind ? valid_in : !valid_in) st = ST_NOFIX;
         else if (!crd_in[0].flags[FL_NONEMPTY] || !crd_in[1].flags[FL_NONEMPTY])
            st = ST_EMPTY;
      end
      st_ok             = (st == ST_OK);
      push_rec.status   = st;
      push_rec.kind     = kind;
      push_rec.lat      = coord_rec(crd_in[0], st_ok);
      push_rec.lon      = coord_rec(crd_in[1], st_ok);
      push_rec.alt_ok   = st_ok && kind && alt_in.got;
      push_rec.alt_neg  = alt_in.neg;
      push_rec.alt_val  = alt_in.acc;
      push_rec.alt_fcnt = alt_in.fcnt[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         phase_ff  <= PH_START;
         csum_ff   <= '0;
         rsum_ff   <= '0;
         hexcnt_ff <= '0;
         tpos_ff   <= '0;
         stype_ff  <= TY_NONE;
         fnum_ff   <= '0;
         fpos_ff   <= '0;
         valid_ff  <= 1'b0;
         crd_ff[0] <= '0;
         crd_ff[1] <= '0;
         alt_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         csum_ff   <= csum_in;
         rsum_ff   <= rsum_in;
         hexcnt_ff <= hexcnt_in;
         tpos_ff   <= tpos_in;
         stype_ff  <= stype_in;
         fnum_ff   <= fnum_in;
         fpos_ff   <= fpos_in;
         valid_ff  <= valid_in;
         crd_ff[0] <= crd_in[0];
         crd_ff[1] <= crd_in[1];
         alt_ff    <= alt_in;
      end
   end

endmodule

// ===== design/nps_queue.sv =====
// Short queue of finished sentences between scanner and converter.
module nps_queue
   import nps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output rec_type head_rec
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   rec_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_rec   = mem_ff[rptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) wptr_in = (wptr_ff == LAST_PTR) ? '0 : wptr_ff + PTR_W'(1);
      if (do_pop) rptr_in = (rptr_ff == LAST_PTR) ? '0 : rptr_ff + PTR_W'(1);
      if (push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (!push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_rec;
   end

endmodule

// ===== design/nps_back.sv =====
// Converter pipeline: fraction scaling, minutes to degrees, saturation.
module nps_back
   import nps_pkg::*;
#(
   parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  rec_type     head_rec,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_status,
   output logic        rsp_kind,
   output logic [31:0] rsp_lat,
   output logic [31:0] rsp_lon,
   output logic [31:0] rsp_alt
);

   function automatic longint pow10(int n);
      longint v;
      v = 1;
      for (int k = 0; k < n; k++) v = v * 10;
      return v;
   endfunction

   localparam int NSTEP = (FRAC_DIGITS > 3) ? FRAC_DIGITS : 3;
   localparam logic [19:0] SCALE     = 20'(pow10(7 - FRAC_DIGITS));
   localparam logic [23:0] DEG_SCALE = 24'd10000000;
   localparam logic [56:0] PCLAMP    = 57'd128849018940;
   localparam logic [35:0] RECIP     = 36'd36650387593;
   localparam logic [17:0] RECIP_LO  = RECIP[17:0];
   localparam logic [17:0] RECIP_HI  = RECIP[35:18];

   function automatic logic [MIN_W-1:0] mul10(logic [MIN_W-1:0] x);
      logic [43:0] p;
      p = ({4'd0, x} << 3) + ({4'd0, x} << 1);
      return (|p[43:40]) ? {MIN_W{1'b1}} : p[39:0];
   endfunction

   function automatic logic [31:0] pack32(logic [39:0] mag, logic neg);
      logic [39:0] m;
      if (neg) begin
         m = (mag > 40'h80000000) ? 40'h80000000 : mag;
         return 32'd0 - m[31:0];
      end
      return (mag > 40'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
   endfunction

   rec_type      stg_ff [NSTEP+1];
   logic [NSTEP:0] stg_vld_ff;

   logic         a_vld_ff, b_vld_ff, c_vld_ff, rsp_vld_ff;
   logic [2:0]   a_st_ff, b_st_ff, c_st_ff;
   logic         a_kind_ff, b_kind_ff, c_kind_ff;
   logic [31:0]  a_alt_ff, b_alt_ff, c_alt_ff;
   logic [1:0]   a_ok_ff, b_ok_ff, c_ok_ff;
   logic [1:0]   a_neg_ff, b_neg_ff, c_neg_ff;
   logic [56:0]  a_prod_ff [2];
   logic [33:0]  a_whole_ff [2];
   logic [33:0]  b_whole_ff [2];
   logic [52:0]  b_lo_ff [2];
   logic [52:0]  b_hi_ff [2];
   logic [34:0]  c_mag_ff [2];
   logic [2:0]   rsp_st_ff;
   logic         rsp_kind_ff;
   logic [31:0]  rsp_lat_ff, rsp_lon_ff, rsp_alt_ff;
   logic         adv;

   // The whole pipeline moves as one when the output register can take a value
   assign adv = !rsp_vld_ff || rsp_tready;
   assign pop = adv && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= '0;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         stg_vld_ff <= {stg_vld_ff[NSTEP-1:0], head_valid};
         a_vld_ff   <= stg_vld_ff[NSTEP];
         b_vld_ff   <= a_vld_ff;
         c_vld_ff   <= b_vld_ff;
         rsp_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [36:0] v;
      logic [56:0] pc;
      logic [34:0] x;
      logic [70:0] sum;
      crec_type    cr;
      rec_type     nx;
      if (adv) begin
         stg_ff[0] <= head_rec;
         // One digit of fraction padding per stage
         for (int k = 0; k < NSTEP; k++) begin
            nx = stg_ff[k];
            if (k < FRAC_DIGITS && 3'(k) >= stg_ff[k].lat.fcnt)
               nx.lat.minutes = mul10(stg_ff[k].lat.minutes);
            if (k < FRAC_DIGITS && 3'(k) >= stg_ff[k].lon.fcnt)
               nx.lon.minutes = mul10(stg_ff[k].lon.minutes);
            if (k < 3 && 2'(k) >= stg_ff[k].alt_fcnt)
               nx.alt_val = mul10(stg_ff[k].alt_val);
            stg_ff[k+1] <= nx;
         end
         a_st_ff   <= stg_ff[NSTEP].status;
         a_kind_ff <= stg_ff[NSTEP].kind;
         a_alt_ff  <= stg_ff[NSTEP].alt_ok
                      ? pack32(stg_ff[NSTEP].alt_val, stg_ff[NSTEP].alt_neg) : 32'd0;
         for (int s = 0; s < 2; s++) begin
            cr = (s == 0) ? stg_ff[NSTEP].lat : stg_ff[NSTEP].lon;
            // Anything beyond 37 bits saturates the result anyway
            v  = (|cr.minutes[39:37]) ? {37{1'b1}} : cr.minutes[36:0];
            a_prod_ff[s]  <= {20'd0, v} * {37'd0, SCALE};
            a_whole_ff[s] <= {24'd0, cr.whole} * {10'd0, DEG_SCALE};
            a_ok_ff[s]    <= cr.ok;
            a_neg_ff[s]   <= cr.neg;
         end
         b_st_ff   <= a_st_ff;
         b_kind_ff <= a_kind_ff;
         b_alt_ff  <= a_alt_ff;
         b_ok_ff   <= a_ok_ff;
         b_neg_ff  <= a_neg_ff;
         for (int s = 0; s < 2; s++) begin
            pc = (a_prod_ff[s] > PCLAMP) ? PCLAMP : a_prod_ff[s];
            x  = pc[36:2];
            b_lo_ff[s]    <= {18'd0, x} * {35'd0, RECIP_LO};
            b_hi_ff[s]    <= {18'd0, x} * {35'd0, RECIP_HI};
            b_whole_ff[s] <= a_whole_ff[s];
         end
         c_st_ff   <= b_st_ff;
         c_kind_ff <= b_kind_ff;
         c_alt_ff  <= b_alt_ff;
         c_ok_ff   <= b_ok_ff;
         c_neg_ff  <= b_neg_ff;
         for (int s = 0; s < 2; s++) begin
            sum = {b_hi_ff[s], 18'd0} + {18'd0, b_lo_ff[s]};
            c_mag_ff[s] <= {1'b0, b_whole_ff[s]} + {3'd0, sum[70:39]};
         end
         rsp_st_ff   <= c_st_ff;
         rsp_kind_ff <= c_kind_ff;
         rsp_alt_ff  <= c_alt_ff;
         rsp_lat_ff  <= c_ok_ff[0] ? pack32({5'd0, c_mag_ff[0]}, c_neg_ff[0]) : 32'd0;
         rsp_lon_ff  <= c_ok_ff[1] ? pack32({5'd0, c_mag_ff[1]}, c_neg_ff[1]) : 32'd0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_status = rsp_st_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_lat    = rsp_lat_ff;
   assign rsp_lon    = rsp_lon_ff;
   assign rsp_alt    = rsp_alt_ff;

endmodule
